// ===== src/iosr_pkg.sv =====
// Shared types for the in-order sequence release block: controller states,
// result status codes and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iosr_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_FETCH
  } ctrl_state_e;

  typedef enum logic [2:0] {
    ST_RELEASED = 3'd0,
    ST_HELD     = 3'd1,
    ST_STALE    = 3'd2,
    ST_BEYOND   = 3'd3,
    ST_DUP      = 3'd4
  } status_e;

  typedef struct packed {
    logic capture;    // latch the incoming beat
    logic eval_fire;  // act on the latched beat
    logic scan_step;  // push the pending release, advance if another is held
    logic fetch;      // load the held handle read from the window store
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic is_release; // latched number equals the expected number
    logic more;       // slot of the expected number is occupied
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/iosr_ctrl.sv =====
// Controller state machine for the in-order sequence release block.
// Depends on iosr_pkg; drives iosr_dp through ctrl_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module iosr_ctrl
  import iosr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        // A release only loads the pending slot; other outcomes need the output.
        if (stat_i.is_release) begin
          cmd_o.eval_fire = 1'b1;
          state_d         = S_SCAN;
        end else if (stat_i.out_free) begin
          cmd_o.eval_fire = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.out_free) begin
          cmd_o.scan_step = 1'b1;
          state_d         = stat_i.more ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_SCAN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/iosr_dp.sv =====
// Datapath for the in-order sequence release block: expected number, window
// store with valid bits, pending release and output register. Depends on iosr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iosr_dp
  import iosr_pkg::*;
#(
  parameter int WINDOW      = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] in_seq_i,
  input  wire logic [15:0] in_handle_i,
  input  wire ctrl_cmd_t   cmd_i,
  output dp_stat_t         stat_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_seq_o,
  output logic [15:0]      out_handle_o,
  output logic [2:0]       out_status_o,
  output logic             out_last_o
);

  localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam int SW = $clog2(WINDOW);

  logic [31:0]       seq_q;
  logic [HW-1:0]     hdl_q;
  logic [31:0]       exp_q;
  logic [SW-1:0]     base_q;
  logic [WINDOW-1:0] valid_q;
  logic [HW-1:0]     mem [WINDOW];
  logic [HW-1:0]     rdata_q;
  logic [31:0]       pend_seq_q;
  logic [HW-1:0]     pend_hdl_q;
  logic              out_valid_q;
  logic [31:0]       out_seq_q;
  logic [HW-1:0]     out_hdl_q;
  status_e           out_status_q;
  logic              out_last_q;

  logic [31:0] diff;
  logic        is_eq, is_lt, beyond, dup;
  logic [SW:0] slot_sum;
  logic [SW-1:0] slot;
  logic [SW-1:0] base_nxt;
  status_e     cls;
  logic        out_free, more, push;
  logic        wr_en, rd_en;

  assign is_eq    = (seq_q == exp_q);
  assign is_lt    = (seq_q < exp_q);
  assign diff     = seq_q - exp_q;
  assign beyond   = (diff >= 32'(WINDOW));
  // Slot of seq_q is base plus offset, folded once into the window.
  assign slot_sum = {1'b0, base_q} + {1'b0, diff[SW-1:0]};
  assign slot     = (slot_sum >= (SW + 1)'(WINDOW)) ?
                    SW'(slot_sum - (SW + 1)'(WINDOW)) : slot_sum[SW-1:0];
  assign dup      = valid_q[slot];

  always_comb begin
    priority if (is_eq) begin
      cls = ST_RELEASED;
    end else if (is_lt) begin
      cls = ST_STALE;
    end else if (beyond) begin
      cls = ST_BEYOND;
    end else if (dup) begin
      cls = ST_DUP;
    end else begin
      cls = ST_HELD;
    end
  end

  // The counter wrap restarts the slot index at zero.
  assign base_nxt = ((exp_q == '1) || (base_q == SW'(WINDOW - 1))) ? '0 : base_q + 1'b1;

  assign more     = valid_q[base_q];
  assign out_free = !out_valid_q || out_ready_i;
  assign push     = (cmd_i.eval_fire && !is_eq) || cmd_i.scan_step;
  assign wr_en    = cmd_i.eval_fire && (cls == ST_HELD);
  assign rd_en    = cmd_i.scan_step && more;

  assign stat_o.out_free   = out_free;
  assign stat_o.is_release = is_eq;
  assign stat_o.more       = more;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seq_q <= in_seq_i;
      hdl_q <= in_handle_i[HW-1:0];
    end
    if (cmd_i.eval_fire && is_eq) begin
      pend_seq_q <= seq_q;
      pend_hdl_q <= hdl_q;
    end else if (rd_en) begin
      pend_seq_q <= exp_q;
    end else if (cmd_i.fetch) begin
      pend_hdl_q <= rdata_q;
    end
    if (cmd_i.eval_fire && !is_eq) begin
      out_seq_q    <= seq_q;
      out_hdl_q    <= hdl_q;
      out_status_q <= cls;
      out_last_q   <= 1'b1;
    end else if (cmd_i.scan_step) begin
      out_seq_q    <= pend_seq_q;
      out_hdl_q    <= pend_hdl_q;
      out_status_q <= ST_RELEASED;
      out_last_q   <= !more;
    end
  end

  // Window store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[slot] <= hdl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[base_q];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= '0;
      base_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((cmd_i.eval_fire && is_eq) || rd_en) begin
        exp_q  <= exp_q + 32'd1;
        base_q <= base_nxt;
      end
      if (wr_en) begin
        valid_q[slot] <= 1'b1;
      end else if (rd_en) begin
        valid_q[base_q] <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_seq_o    = out_seq_q;
  assign out_handle_o = 16'(out_hdl_q);
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== src/in_order_sequence_release.sv =====
// Top level of the in-order sequence release block (sequence reorder buffer).
// Instantiates iosr_ctrl and iosr_dp; uses iosr_pkg.
//
//   port group  dir  tdata (low bit up)            tuser     tlast
//   s_axis      in   seq_id[31:0], handle[47:32]   -         -
//   m_axis      out  out_seq[31:0], out_handle     status    last
//
// A stale, beyond-window, duplicate or held beat is captured, then acted on
// once the output is free. A release is captured, set pending, pushed; each
// held message after it is fetched via the registered read port, then pushed.
// Reset clears the expected number and all slot valid bits at once.
// A stalled m_axis holds the result register; the next beat is still captured.
`timescale 1ns / 1ps
`default_nettype none

module in_order_sequence_release
  import iosr_pkg::*;
#(
  parameter int WINDOW      = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // seq_id [31:0], handle [47:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // out_seq [31:0], out_handle [47:32]
  output logic [2:0]       m_axis_tuser,   // status [2:0]
  output logic             m_axis_tlast
);

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic [31:0] out_seq;
  logic [15:0] out_handle;

  iosr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iosr_dp #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_seq_i     (s_axis_tdata[31:0]),
    .in_handle_i  (s_axis_tdata[47:32]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_seq_o    (out_seq),
    .out_handle_o (out_handle),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_handle, out_seq};

endmodule

`default_nettype wire
